### sv/irdq_pkg.sv
// Shared types and constants for the IR ring direction qualifier.
// No dependencies; the other files that use this package refer to it by scoped names.
package irdq_pkg;

	localparam int unsigned SensorCount = 8;

	// Event codes reported with every result
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STOP    = 3'd1,
		EV_NEW_DIR = 3'd2,
		EV_HOLD    = 3'd3,
		EV_REFRESH = 3'd4
	} event_kind_t;

	// Register indexes on the configuration port
	typedef enum logic {
		REG_SETTLE_COUNT        = 1'b0,
		REG_REFRESH_INTERVAL_MS = 1'b1
	} reg_index_t;

	localparam logic [3:0]  ThresholdReset = 4'd3;
	localparam logic [15:0] IntervalReset  = 16'd3000;
	localparam logic signed [3:0] NoDirection = -4'sd1;

	typedef struct packed {
		logic [3:0]  settle_count;
		logic [15:0] refresh_interval_ms;
	} cfg_t;

	// Classified sample handed from front to back
	typedef struct packed {
		logic signed [3:0] raw_direction;
		logic [31:0]       now_ms;
	} queue_entry_t;

	// Sensor index to degrees
	function automatic logic [8:0] angle_of(input logic [2:0] dir);
		logic [8:0] a;
		unique case (dir)
			3'd0: a = 9'd0;
			3'd1: a = 9'd45;
			3'd2: a = 9'd90;
			3'd3: a = 9'd135;
			3'd4: a = 9'd180;
			3'd5: a = 9'd225;
			3'd6: a = 9'd270;
			3'd7: a = 9'd315;
			default: a = 9'd0;
		endcase
		return a;
	endfunction

endpackage

### sv/irdq_stream_if.sv
// Valid/ready stream interfaces for the sample input and the result output.
// No dependencies.
interface irdq_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  sensor_levels;
	logic [31:0] now_ms;

	modport source (output valid, output sensor_levels, output now_ms, input ready);
	modport sink   (input valid, input sensor_levels, input now_ms, output ready);
endinterface

interface irdq_out_if;
	logic              valid;
	logic              ready;
	logic [2:0]        event_kind;
	logic signed [3:0] direction;
	logic [8:0]        angle_deg;
	logic signed [3:0] raw_direction;

	modport source (output valid, output event_kind, output direction, output angle_deg,
		output raw_direction, input ready);
	modport sink   (input valid, input event_kind, input direction, input angle_deg,
		input raw_direction, output ready);
endinterface

### sv/ir_ring_direction_qualifier_core.sv
// Top level of the IR ring direction qualifier: APB registers, front, queue, back.
// Depends on irdq_pkg, irdq_stream_if, irdq_front, irdq_queue and irdq_back.
//
//  channel  | role   | transaction                  | fields
//  ---------+--------+------------------------------+-------------------------------------
//  in       | sink   | in.valid & in.ready          | sensor_levels[7:0], now_ms[31:0]
//  out      | source | out.valid & out.ready        | event_kind, direction, angle_deg,
//           |        |                              | raw_direction
//  apb      | slave  | psel & penable & pwrite      | paddr[2] picks register, pwdata
//
// One sample per cycle sustained while the out channel is not stalled; each sample gives exactly one result.
// A sample is registered in the queue, then in the result register of the back end.
// The back end's debounce state updates on each pop, so it keeps up with the one-per-cycle rate.
// arst_n clears queue pointers, debounce state, the result valid and restores register defaults.
// A stalled out channel fills the QUEUE_DEPTH queue, after which in.ready drops.
module ir_ring_direction_qualifier_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// streams
	irdq_in_if.sink     in,
	irdq_out_if.source  out
);

	irdq_pkg::cfg_t cfg_q;
	irdq_pkg::reg_index_t reg_sel;

	logic                   push;
	irdq_pkg::queue_entry_t push_data;
	logic                   full;
	logic                   head_valid;
	logic                   pop;
	irdq_pkg::queue_entry_t head_data;

	// Registers are word aligned; paddr[2] selects, the byte bits are ignored.
	assign reg_sel = irdq_pkg::reg_index_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_count        <= irdq_pkg::ThresholdReset;
			cfg_q.refresh_interval_ms <= irdq_pkg::IntervalReset;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				irdq_pkg::REG_SETTLE_COUNT:        cfg_q.settle_count        <= pwdata[3:0];
				irdq_pkg::REG_REFRESH_INTERVAL_MS: cfg_q.refresh_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			irdq_pkg::REG_SETTLE_COUNT:        prdata = {28'd0, cfg_q.settle_count};
			irdq_pkg::REG_REFRESH_INTERVAL_MS: prdata = {16'd0, cfg_q.refresh_interval_ms};
			default:                           prdata = '0;
		endcase
	end

	// Front: selection is pure logic, the sample lands straight in the queue
	irdq_front u_front (
		.in        (in),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	irdq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	// Back: pops whenever the result register is free or being drained
	irdq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out        (out)
	);

endmodule

### sv/irdq_front.sv
// Front end: takes sample transactions and picks the raw direction.
// Depends on irdq_pkg and irdq_in_if.
module irdq_front (
	irdq_in_if.sink              in,
	input  logic                 full,
	output logic                 push,
	output irdq_pkg::queue_entry_t push_data
);

	logic [7:0] active;
	logic [7:0] kept;
	logic [7:0] sel;
	logic [3:0] n;
	logic [3:0] target;
	logic [3:0] seen;
	logic signed [3:0] raw;

	always_comb begin
		active = ~in.sensor_levels;
		kept   = active & ~8'h38;
		// a front sensor masks the rear group, unless that empties the set
		if ((active & 8'h83) != 8'h00 && kept != 8'h00) begin
			sel = kept;
		end else begin
			sel = active;
		end
		n = '0;
		for (int i = 0; i < irdq_pkg::SensorCount; i++) begin
			n = n + {3'b000, sel[i]};
		end
		target = n >> 1;
		seen   = '0;
		raw    = irdq_pkg::NoDirection;
		for (int i = 0; i < irdq_pkg::SensorCount; i++) begin
			if (sel[i]) begin
				if (seen == target) begin
					raw = $signed({1'b0, 3'(i)});
				end
				seen = seen + 4'd1;
			end
		end
	end

	assign in.ready                = !full;
	assign push                    = in.valid && !full;
	assign push_data.raw_direction = raw;
	assign push_data.now_ms        = in.now_ms;

endmodule

### sv/irdq_queue.sv
// Short queue of classified samples between front and back.
// Depends on irdq_pkg.
module irdq_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  irdq_pkg::queue_entry_t push_data,
	output logic                   full,
	output logic                   head_valid,
	input  logic                   pop,
	output irdq_pkg::queue_entry_t head_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	irdq_pkg::queue_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/irdq_back.sv
// Back end: debounce, event decision, refresh timing and the result register.
// Depends on irdq_pkg and irdq_out_if.
module irdq_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  irdq_pkg::cfg_t         cfg,
	input  logic                   head_valid,
	input  irdq_pkg::queue_entry_t head_data,
	output logic                   pop,
	irdq_out_if.source             out
);

	logic signed [3:0] last_cand_q;
	logic [3:0]        run_q;
	logic signed [3:0] accepted_q;
	logic [31:0]       last_refresh_q;

	logic              out_valid_q;
	irdq_pkg::event_kind_t kind_q;
	logic signed [3:0] dir_q;
	logic [8:0]        angle_q;
	logic signed [3:0] raw_q;

	logic signed [3:0] raw;
	logic [3:0]        run_d;
	logic [31:0]       elapsed;
	logic              stable;
	logic              due;
	irdq_pkg::event_kind_t kind_d;
	logic signed [3:0] dir_d;

	assign raw = head_data.raw_direction;
	assign pop = head_valid && (!out_valid_q || out.ready);

	always_comb begin
		if (raw == last_cand_q) begin
			run_d = (run_q == 4'd15) ? run_q : run_q + 4'd1;
		end else begin
			run_d = 4'd1;
		end
		stable  = (run_d >= cfg.settle_count);
		elapsed = head_data.now_ms - last_refresh_q;
		due     = (elapsed >= {16'd0, cfg.refresh_interval_ms});
		dir_d   = irdq_pkg::NoDirection;
		priority if (raw[3]) begin
			kind_d = irdq_pkg::EV_STOP;
		end else if (!stable) begin
			kind_d = irdq_pkg::EV_NONE;
		end else if (raw != accepted_q) begin
			kind_d = irdq_pkg::EV_NEW_DIR;
			dir_d  = raw;
		end else if (due) begin
			kind_d = irdq_pkg::EV_REFRESH;
			dir_d  = raw;
		end else begin
			kind_d = irdq_pkg::EV_HOLD;
			dir_d  = raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cand_q    <= irdq_pkg::NoDirection;
			run_q          <= '0;
			accepted_q     <= irdq_pkg::NoDirection;
			last_refresh_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			// a gap in the signal leaves the debounce state alone
			if (pop && !raw[3]) begin
				run_q       <= run_d;
				last_cand_q <= raw;
				if (kind_d == irdq_pkg::EV_NEW_DIR) begin
					accepted_q <= raw;
				end
				if (kind_d == irdq_pkg::EV_REFRESH) begin
					last_refresh_q <= head_data.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= kind_d;
			dir_q   <= dir_d;
			angle_q <= dir_d[3] ? 9'd0 : irdq_pkg::angle_of(dir_d[2:0]);
			raw_q   <= raw;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.event_kind    = kind_q;
	assign out.direction     = dir_q;
	assign out.angle_deg     = angle_q;
	assign out.raw_direction = raw_q;

endmodule

### sv/irdq_checker.sv
// Port-level assertions for the qualifier and the bind that attaches them.
// Depends on irdq_pkg and ir_ring_direction_qualifier_core.
module irdq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        event_kind,
	input logic signed [3:0] direction,
	input logic [8:0]        angle_deg,
	input logic signed [3:0] raw_direction
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(direction)
			&& $stable(raw_direction))
		else $error("result changed while stalled");

	// no reported direction for none and stop
	a_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == irdq_pkg::EV_NONE || event_kind == irdq_pkg::EV_STOP)
			|-> direction == irdq_pkg::NoDirection && angle_deg == 9'd0)
		else $error("direction reported without a stable signal");

	// stop exactly when the sample had no active sensor
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == irdq_pkg::EV_STOP) == (raw_direction == irdq_pkg::NoDirection)))
		else $error("stop event and raw direction disagree");

	// a reported direction is the raw pick, with its angle
	a_dir_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == irdq_pkg::EV_NEW_DIR || event_kind == irdq_pkg::EV_HOLD
			|| event_kind == irdq_pkg::EV_REFRESH)
			|-> direction == raw_direction && angle_deg == irdq_pkg::angle_of(direction[2:0]))
		else $error("reported direction differs from raw pick");

endmodule

bind ir_ring_direction_qualifier_core irdq_checker u_irdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out.valid),
	.out_ready     (out.ready),
	.event_kind    (out.event_kind),
	.direction     (out.direction),
	.angle_deg     (out.angle_deg),
	.raw_direction (out.raw_direction)
);
